### design/bgft_pkg.sv
// Shared types, register indexes and curve constants for the battery gauge.
// No dependencies; every other design file imports this package.
package bgft_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DIVIDER_RATIO   = 2'd0,
    REG_FILTER_ALPHA    = 2'd1,
    REG_TREND_WINDOW_MS = 2'd2,
    REG_CHARGE_RISE_MV  = 2'd3
  } reg_index_t;

  localparam logic [14:0] DIVIDER_RATIO_RST   = 15'd8192;
  localparam logic [15:0] FILTER_ALPHA_RST    = 16'd6554;
  localparam logic [31:0] TREND_WINDOW_MS_RST = 32'd60000;
  localparam logic [9:0]  CHARGE_RISE_MV_RST  = 10'd20;

  typedef struct packed {
    logic [14:0] divider_ratio;
    logic [15:0] filter_alpha;
    logic [31:0] trend_window_ms;
    logic [9:0]  charge_rise_mv;
  } cfg_t;

  // One finished burst handed from the front to the back
  typedef struct packed {
    logic [11:0] avg;
    logic [31:0] now;
  } burst_t;

  localparam logic [29:0] Q30_MAX   = 30'h3FFF_FFFF;
  localparam logic [12:0] CHARGE_MV = 13'd4150;

  // LiPo open-circuit curve: millivolts and percent at each knee
  localparam int CURVE_POINTS = 6;
  localparam logic [12:0] CURVE_MV  [CURVE_POINTS] =
    '{13'd3300, 13'd3600, 13'd3700, 13'd3900, 13'd4050, 13'd4200};
  localparam logic [6:0]  CURVE_PCT [CURVE_POINTS] =
    '{7'd0, 7'd5, 7'd20, 7'd60, 7'd90, 7'd100};

  // Slope of each segment reduced to num/den; den is applied as a
  // reciprocal scaled by 2^15 (exact for the segment's quotient range).
  function automatic logic [1:0] seg_num(input logic [2:0] seg);
    logic [1:0] num;
    begin
      case (seg)
        3'd2:    num = 2'd3;  // 15 over 100 mV
        default: num = 2'd1;
      endcase
      return num;
    end
  endfunction

  function automatic logic [12:0] seg_recip(input logic [2:0] seg);
    logic [12:0] recip;
    begin
      case (seg)
        3'd1:    recip = 13'd547;   // 1/60
        3'd2:    recip = 13'd1639;  // 1/20
        3'd3:    recip = 13'd6554;  // 1/5
        3'd4:    recip = 13'd6554;  // 1/5
        3'd5:    recip = 13'd2185;  // 1/15
        default: recip = 13'd0;
      endcase
      return recip;
    end
  endfunction

endpackage

### design/battery_gauge_filter_trend.sv
// Battery gauge: one ADC pin sample (mV plus ms timestamp) enters per cycle
// while full is low; every SAMPLES samples form a burst whose floor average is
// scaled by divider_ratio, smoothed by an exponential filter (Q14.16 mV), checked
// against the value at the start of the trend window and mapped to percent on a
// six-knee LiPo curve. One result per burst appears on the output queue side.
// The back-end sequencer steps each burst through scale, difference, alpha
// multiply, update, trend and segment, divide and result load, and takes no
// new burst until the last result is loaded; a two-entry queue lets the front
// keep accepting samples meanwhile. Depends on bgft_pkg and the bgft_* modules.
module battery_gauge_filter_trend import bgft_pkg::*; #(
  parameter int SAMPLES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [11:0] pin_mv,
  input  logic [31:0] now_ms,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] pin_avg_mv,
  output logic [13:0] pack_mv,
  output logic [6:0]  percent,
  output logic        charging,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t   cfg;
  burst_t front_data;
  burst_t back_data;
  logic   front_push;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.divider_ratio   <= DIVIDER_RATIO_RST;
      cfg.filter_alpha    <= FILTER_ALPHA_RST;
      cfg.trend_window_ms <= TREND_WINDOW_MS_RST;
      cfg.charge_rise_mv  <= CHARGE_RISE_MV_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_DIVIDER_RATIO:   cfg.divider_ratio   <= cfg_data[14:0];
        REG_FILTER_ALPHA:    cfg.filter_alpha    <= cfg_data[15:0];
        REG_TREND_WINDOW_MS: cfg.trend_window_ms <= cfg_data;
        REG_CHARGE_RISE_MV:  cfg.charge_rise_mv  <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  bgft_front #(
    .SAMPLES (SAMPLES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pin_mv (pin_mv),
    .now_ms (now_ms),
    .full   (full),
    .q_data (front_data),
    .q_push (front_push),
    .q_full (q_full)
  );

  bgft_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_data (front_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (back_data),
    .empty     (q_empty)
  );

  bgft_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_data     (back_data),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .pin_avg_mv (pin_avg_mv),
    .pack_mv    (pack_mv),
    .percent    (percent),
    .charging   (charging)
  );

endmodule

### design/bgft_front.sv
// Front end: sums pin samples over a burst and forms the burst average.
// Depends on bgft_pkg; feeds bgft_queue.
module bgft_front import bgft_pkg::*; #(
  parameter int SAMPLES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [11:0] pin_mv,
  input  logic [31:0] now_ms,
  output logic        full,
  output burst_t      q_data,
  output logic        q_push,
  input  logic        q_full
);

  localparam int          SHIFT = 18;
  localparam logic [2:0]  LAST  = 3'(SAMPLES - 1);
  localparam logic [18:0] RECIP = 19'(((2 ** SHIFT) + SAMPLES - 1) / SAMPLES);

  logic [14:0] sample_sum;
  logic [14:0] sum_next;
  logic [2:0]  sample_count;
  logic [14:0] burst_sum;
  logic [31:0] burst_now;
  logic        burst_valid;
  logic        accept;
  logic [33:0] avg_prod;

  assign accept   = push && !full;
  assign full     = burst_valid && q_full;
  assign q_push   = burst_valid && !q_full;
  assign sum_next = sample_sum + {3'b000, pin_mv};

  // Burst accumulation and hand-off flag
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
      burst_valid  <= 1'b0;
    end else begin
      // a new burst end takes the slot that the queue frees in the same cycle
      if (accept && sample_count == LAST) begin
        burst_valid <= 1'b1;
      end else if (q_push) begin
        burst_valid <= 1'b0;
      end
      if (accept) begin
        if (sample_count == LAST) begin
          sample_sum   <= '0;
          sample_count <= '0;
        end else begin
          sample_sum   <= sum_next;
          sample_count <= sample_count + 3'd1;
        end
      end
    end
  end

  // Hold the completed burst until the queue takes it
  always_ff @(posedge clk) begin
    if (accept && sample_count == LAST) begin
      burst_sum <= sum_next;
      burst_now <= now_ms;
    end
  end

  // Floor average by reciprocal multiply
  assign avg_prod = 34'(burst_sum) * 34'(RECIP);
  assign q_data   = {avg_prod[SHIFT+11:SHIFT], burst_now};

endmodule

### design/bgft_queue.sv
// Two-entry queue between the front end and the back-end sequencer.
// Depends on bgft_pkg for the burst record.
module bgft_queue import bgft_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  burst_t push_data,
  output logic   full,
  input  logic   pop,
  output burst_t pop_data,
  output logic   empty
);

  burst_t     entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_ok;
  logic       pop_ok;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 2'd1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 2'd1;
      end
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### design/bgft_back.sv
// Back-end sequencer: scale, exponential filter, charge trend, state of charge
// and the result register. Depends on bgft_pkg; pulls bursts from bgft_queue.
module bgft_back import bgft_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  burst_t      q_data,
  input  logic        q_empty,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [11:0] pin_avg_mv,
  output logic [13:0] pack_mv,
  output logic [6:0]  percent,
  output logic        charging
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCALE = 8'b0000_0010,
    S_DIFF  = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_UPD   = 8'b0001_0000,
    S_TREND = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t      state;
  state_t      state_next;

  logic [11:0] avg;
  logic [31:0] now_r;
  logic [29:0] mq;
  logic [29:0] filtered_q;
  logic        filter_seeded;
  logic        trend_started;
  logic [31:0] window_start_ms;
  logic [29:0] window_start_q;
  logic        rising_flag;
  logic        ge;
  logic [29:0] diff;
  logic [29:0] step;
  logic [8:0]  soc_y;
  logic [12:0] soc_m;
  logic [6:0]  soc_base;
  logic [6:0]  pct_r;
  logic        out_valid;
  logic        out_load;

  logic [26:0] meas;
  logic [30:0] meas_q;
  logic [29:0] mq_sat;
  logic [45:0] alpha_prod;
  logic [31:0] elapsed;
  logic [30:0] delta;
  logic [30:0] rise_q;
  logic [2:0]  seg;
  logic [24:0] soc_off;
  logic [26:0] soc_x;
  logic [21:0] div_prod;

  assign empty    = !out_valid;
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign out_load = (state == S_OUT) && (!out_valid || pop);

  // Scale the average to Q16 pack millivolts and saturate
  assign meas   = 27'(avg) * 27'(cfg.divider_ratio);
  assign meas_q = {meas, 4'b0000};
  assign mq_sat = meas_q[30] ? Q30_MAX : meas_q[29:0];

  assign alpha_prod = 46'(cfg.filter_alpha) * 46'(diff);

  // Trend window comparison, signed over 31 bits
  assign elapsed = now_r - window_start_ms;
  assign delta   = {1'b0, filtered_q} - {1'b0, window_start_q};
  assign rise_q  = {5'b00000, cfg.charge_rise_mv, 16'h0000};

  // Pick the curve segment closed by the first knee at or above the voltage
  always_comb begin
    seg = 3'd5;
    for (int i = CURVE_POINTS - 2; i >= 1; i--) begin
      if (filtered_q <= {CURVE_MV[i], 16'h0000}) begin
        seg = 3'(i);
      end
    end
  end

  assign soc_off  = 25'(filtered_q - {CURVE_MV[seg - 3'd1], 16'h0000});
  assign soc_x    = 27'(soc_off) * 27'(seg_num(seg));
  assign div_prod = 22'(soc_y) * 22'(soc_m);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (!q_empty) state_next = S_SCALE;
      S_SCALE: state_next = S_DIFF;
      S_DIFF:  state_next = S_MUL;
      S_MUL:   state_next = S_UPD;
      S_UPD:   state_next = S_TREND;
      S_TREND: state_next = S_DIV;
      S_DIV:   state_next = S_OUT;
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      filter_seeded <= 1'b0;
      trend_started <= 1'b0;
      rising_flag   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SCALE) begin
        filter_seeded <= 1'b1;
      end
      if (state == S_TREND) begin
        trend_started <= 1'b1;
        if (trend_started && elapsed >= cfg.trend_window_ms) begin
          rising_flag <= ($signed(delta) >= $signed(rise_q));
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        avg   <= q_data.avg;
        now_r <= q_data.now;
      end
      S_SCALE: begin
        mq <= mq_sat;
        if (!filter_seeded) begin
          filtered_q <= mq_sat;
        end
      end
      S_DIFF: begin
        ge   <= (mq >= filtered_q);
        diff <= (mq >= filtered_q) ? (mq - filtered_q) : (filtered_q - mq);
      end
      S_MUL: begin
        step <= alpha_prod[45:16];
      end
      S_UPD: begin
        filtered_q <= ge ? (filtered_q + step) : (filtered_q - step);
      end
      S_TREND: begin
        if (!trend_started || elapsed >= cfg.trend_window_ms) begin
          window_start_ms <= now_r;
          window_start_q  <= filtered_q;
        end
        soc_m <= seg_recip(seg);
        if (filtered_q <= {CURVE_MV[0], 16'h0000}) begin
          soc_base <= CURVE_PCT[0];
          soc_y    <= '0;
        end else if (filtered_q >= {CURVE_MV[CURVE_POINTS-1], 16'h0000}) begin
          soc_base <= CURVE_PCT[CURVE_POINTS-1];
          soc_y    <= '0;
        end else begin
          soc_base <= CURVE_PCT[seg - 3'd1];
          soc_y    <= soc_x[24:16];
        end
      end
      S_DIV: begin
        pct_r <= soc_base + div_prod[21:15];
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      pin_avg_mv <= avg;
      pack_mv    <= filtered_q[29:16];
      percent    <= pct_r;
      charging   <= rising_flag && (filtered_q >= {CHARGE_MV, 16'h0000});
    end
  end

endmodule
